// ----- sv/line_follow_differential_drive_pid_unit_assert.svh -----
// Assertion macros used by lfdd_ctrl. The using module provides clk and rst.
`ifndef LINE_FOLLOW_DIFFERENTIAL_DRIVE_PID_UNIT_ASSERT_SVH
`define LINE_FOLLOW_DIFFERENTIAL_DRIVE_PID_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LFDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lfdd_pkg.sv -----
package lfdd_pkg;

  localparam int DEV_W      = 11;
  localparam int CNT_W      = 16;
  localparam int TS_W       = 12;
  localparam int TC_W       = 12;
  localparam int GAIN_W     = 23;
  localparam int LIMIT_W    = 15;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 16;
  localparam int CFG_W      = 23;
  localparam int IDX_W      = 3;
  localparam int ERR_W      = 17;
  localparam int INT_W      = 32;
  localparam int MA_W       = GAIN_W + 1;
  localparam int MB_W       = INT_W + 1;
  localparam int P_W        = MA_W + MB_W;
  localparam int ACC_W      = P_W + 1;

  localparam logic [GAIN_W-1:0]  STEER_KP_RESET = 23'd184320;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 15'd7000;
  localparam logic [SCALE_W-1:0] SCALE_RESET    = 16'd2326;

  typedef enum logic [IDX_W-1:0] {
    CFG_STEER_KP = 3'd0,
    CFG_STEER_KI = 3'd1,
    CFG_STEER_KD = 3'd2,
    CFG_WHEEL_KP = 3'd3,
    CFG_WHEEL_KI = 3'd4,
    CFG_WHEEL_KD = 3'd5,
    CFG_LIMIT    = 3'd6,
    CFG_SCALE    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_TS    = 4'd0,
    MUL_SKP   = 4'd1,
    MUL_SKI   = 4'd2,
    MUL_SKD   = 4'd3,
    MUL_WKI_L = 4'd4,
    MUL_WKI_R = 4'd5,
    MUL_WKP_L = 4'd6,
    MUL_WKP_R = 4'd7,
    MUL_WKD_L = 4'd8,
    MUL_WKD_R = 4'd9
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     sint;
    logic     tcnt;
    logic     err;
    logic     wint;
    logic     sacc_clr;
    logic     sacc_add;
    logic     sfin;
    logic     lclamp;
    logic     rclamp;
    logic     lacc;
    logic     racc;
    logic     prev;
    logic     div_start;
    logic     setback;
    logic     out_load;
    mul_sel_t mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clamp_any;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- sv/lfdd_if.sv -----
interface lfdd_in_if;
  import lfdd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DEV_W-1:0] trace_deviation;
  logic signed [CNT_W-1:0] left_count;
  logic signed [CNT_W-1:0] right_count;
  logic signed [TS_W-1:0]  target_speed;

  modport source (output valid, trace_deviation, left_count, right_count, target_speed,
                  input ready);
  modport sink (input valid, trace_deviation, left_count, right_count, target_speed,
                output ready);
endinterface

interface lfdd_out_if #(parameter int DRIVE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [DRIVE_WIDTH-1:0] left_drive;
  logic signed [DRIVE_WIDTH-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

// ----- sv/lfdd_div.sv -----
module lfdd_div #(
  parameter int N = 23,
  parameter int D = 23
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  q;
  logic [D-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [D:0]    shifted;
  logic [D:0]    diff;
  logic          ge;

  assign shifted  = {rem, q[N-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign ge       = shifted >= {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[N-2:0], ge};
      rem <= ge ? diff[D-1:0] : shifted[D-1:0];
    end
  end

endmodule

// ----- sv/lfdd_datapath.sv -----
module lfdd_datapath #(
  parameter int GAIN_FRACTION_BITS = 8,
  parameter int DRIVE_WIDTH        = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [lfdd_pkg::IDX_W-1:0]        wr_index,
  input  logic [lfdd_pkg::CFG_W-1:0]        wr_data,
  input  logic signed [lfdd_pkg::DEV_W-1:0] trace_deviation,
  input  logic signed [lfdd_pkg::CNT_W-1:0] left_count,
  input  logic signed [lfdd_pkg::CNT_W-1:0] right_count,
  input  logic signed [lfdd_pkg::TS_W-1:0]  target_speed,
  input  lfdd_pkg::dp_cmd_t                 cmd,
  output lfdd_pkg::dp_stat_t                stat,
  output logic signed [DRIVE_WIDTH-1:0]     left_drive,
  output logic signed [DRIVE_WIDTH-1:0]     right_drive
);
  import lfdd_pkg::*;

  localparam int LIM_W = LIMIT_W + GAIN_FRACTION_BITS;
  localparam logic signed [ACC_W-1:0] BIAS =
    ACC_W'((64'sd1 <<< GAIN_FRACTION_BITS) - 64'sd1);
  localparam logic signed [P_W-1:0] TC_BIAS = P_W'((64'sd1 <<< SCALE_FRAC) - 64'sd1);
  localparam logic signed [ACC_W:0] DMAX =
    (ACC_W+1)'((64'sd1 <<< (DRIVE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] DMIN = -DMAX - 1;

  function automatic logic signed [INT_W-1:0] acc32(input logic signed [INT_W-1:0] a,
                                                    input logic signed [ERR_W-1:0] b);
    logic signed [INT_W:0] s;
    s = (INT_W+1)'(a) + (INT_W+1)'(b);
    if (s[INT_W] != s[INT_W-1]) begin
      return s[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end
    return s[INT_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] trunc_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    b = v;
    if (v[ACC_W-1]) begin
      b = v + BIAS;
    end
    return b >>> GAIN_FRACTION_BITS;
  endfunction

  function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(input logic signed [ACC_W:0] v);
    if (v > DMAX) begin
      return DMAX[DRIVE_WIDTH-1:0];
    end else if (v < DMIN) begin
      return DMIN[DRIVE_WIDTH-1:0];
    end
    return v[DRIVE_WIDTH-1:0];
  endfunction

  // configuration
  logic [GAIN_W-1:0]  steer_kp, steer_ki, steer_kd;
  logic [GAIN_W-1:0]  wheel_kp, wheel_ki, wheel_kd;
  logic [LIMIT_W-1:0] integral_limit;
  logic [SCALE_W-1:0] speed_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_kp       <= STEER_KP_RESET;
      steer_ki       <= '0;
      steer_kd       <= '0;
      wheel_kp       <= '0;
      wheel_ki       <= '0;
      wheel_kd       <= '0;
      integral_limit <= LIMIT_RESET;
      speed_scale    <= SCALE_RESET;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_STEER_KP: steer_kp <= wr_data;
        CFG_STEER_KI: steer_ki <= wr_data;
        CFG_STEER_KD: steer_kd <= wr_data;
        CFG_WHEEL_KP: wheel_kp <= wr_data;
        CFG_WHEEL_KI: wheel_ki <= wr_data;
        CFG_WHEEL_KD: wheel_kd <= wr_data;
        CFG_LIMIT:    integral_limit <= wr_data[LIMIT_W-1:0];
        CFG_SCALE:    speed_scale <= wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // latched beat
  logic signed [DEV_W-1:0] dev;
  logic signed [CNT_W-1:0] lcnt, rcnt;
  logic signed [TS_W-1:0]  tspd;

  // working registers
  logic signed [TC_W-1:0]  tcount;
  logic signed [ERR_W-1:0] left_err, right_err;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc_s, acc_l, acc_r, steer;

  // controller-visible state
  logic signed [INT_W-1:0] steer_int, left_int, right_int;
  logic signed [DEV_W-1:0] steer_prev;
  logic signed [ERR_W-1:0] left_prev, right_prev;
  logic                    l_hi, l_lo, r_hi, r_lo;

  // shared multiplier
  logic [GAIN_W-1:0]     mul_gain;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_gain = '0;
    mul_b    = '0;
    case (cmd.mul_sel)
      MUL_TS: begin
        mul_gain = GAIN_W'(speed_scale);
        mul_b    = MB_W'(tspd);
      end
      MUL_SKP: begin
        mul_gain = steer_kp;
        mul_b    = MB_W'(dev);
      end
      MUL_SKI: begin
        mul_gain = steer_ki;
        mul_b    = MB_W'(steer_int);
      end
      MUL_SKD: begin
        mul_gain = steer_kd;
        mul_b    = MB_W'(dev) - MB_W'(steer_prev);
      end
      MUL_WKI_L: begin
        mul_gain = wheel_ki;
        mul_b    = MB_W'(left_int);
      end
      MUL_WKI_R: begin
        mul_gain = wheel_ki;
        mul_b    = MB_W'(right_int);
      end
      MUL_WKP_L: begin
        mul_gain = wheel_kp;
        mul_b    = MB_W'(left_err);
      end
      MUL_WKP_R: begin
        mul_gain = wheel_kp;
        mul_b    = MB_W'(right_err);
      end
      MUL_WKD_L: begin
        mul_gain = wheel_kd;
        mul_b    = MB_W'(left_err) - MB_W'(left_prev);
      end
      MUL_WKD_R: begin
        mul_gain = wheel_kd;
        mul_b    = MB_W'(right_err) - MB_W'(right_prev);
      end
      default: ;
    endcase
  end

  // target counts, truncated toward zero
  logic signed [P_W-1:0] tc_sum, tc_full;
  always_comb begin
    tc_sum = prod;
    if (prod[P_W-1]) begin
      tc_sum = prod + TC_BIAS;
    end
    tc_full = tc_sum >>> SCALE_FRAC;
  end

  // integral drive clamp
  logic signed [P_W-1:0] lim_q, iq_clamped;
  logic                  iq_hi, iq_lo;
  assign lim_q = P_W'(integral_limit) << GAIN_FRACTION_BITS;
  assign iq_hi = prod > lim_q;
  assign iq_lo = prod < -lim_q;
  assign iq_clamped = iq_hi ? lim_q : (iq_lo ? -lim_q : prod);

  // set-back value lim / ki
  logic [LIM_W-1:0]        div_num, div_q;
  logic                    div_done;
  logic signed [INT_W-1:0] q32;
  assign div_num = LIM_W'(integral_limit) << GAIN_FRACTION_BITS;
  assign q32     = INT_W'(div_q);

  lfdd_div #(.N(LIM_W), .D(GAIN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (wheel_ki),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.div_done  = div_done;
  assign stat.clamp_any = l_hi | l_lo | r_hi | r_lo;

  // output sums
  logic signed [ACC_W-1:0] lt, rt;
  logic signed [ACC_W:0]   lsum, rsum;
  assign lt   = trunc_q(acc_l);
  assign rt   = trunc_q(acc_r);
  assign lsum = (ACC_W+1)'(lt) - (ACC_W+1)'(steer);
  assign rsum = (ACC_W+1)'(steer) + (ACC_W+1)'(rt);

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_int  <= '0;
      steer_prev <= '0;
      left_int   <= '0;
      left_prev  <= '0;
      right_int  <= '0;
      right_prev <= '0;
      l_hi       <= 1'b0;
      l_lo       <= 1'b0;
      r_hi       <= 1'b0;
      r_lo       <= 1'b0;
    end else begin
      if (cmd.load) begin
        l_hi <= 1'b0;
        l_lo <= 1'b0;
        r_hi <= 1'b0;
        r_lo <= 1'b0;
      end
      if (cmd.sint) begin
        steer_int <= acc32(steer_int, ERR_W'(dev));
      end
      if (cmd.wint) begin
        left_int  <= acc32(left_int, left_err);
        right_int <= acc32(right_int, right_err);
      end
      if (cmd.lclamp) begin
        l_hi <= iq_hi;
        l_lo <= iq_lo;
      end
      if (cmd.rclamp) begin
        r_hi <= iq_hi;
        r_lo <= iq_lo;
      end
      if (cmd.prev) begin
        steer_prev <= dev;
        left_prev  <= left_err;
        right_prev <= right_err;
      end
      if (cmd.setback) begin
        if (l_hi) begin
          left_int <= q32;
        end else if (l_lo) begin
          left_int <= -q32;
        end
        if (r_hi) begin
          right_int <= q32;
        end else if (r_lo) begin
          right_int <= -q32;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_gain}) * mul_b;
    if (cmd.load) begin
      dev  <= trace_deviation;
      lcnt <= left_count;
      rcnt <= right_count;
      tspd <= target_speed;
    end
    if (cmd.tcnt) begin
      tcount <= tc_full[TC_W-1:0];
    end
    if (cmd.err) begin
      left_err  <= ERR_W'(tcount) - ERR_W'(lcnt);
      right_err <= ERR_W'(tcount) - ERR_W'(rcnt);
    end
    if (cmd.sacc_clr) begin
      acc_s <= ACC_W'(prod);
    end else if (cmd.sacc_add) begin
      acc_s <= acc_s + ACC_W'(prod);
    end
    if (cmd.sfin) begin
      steer <= trunc_q(acc_s + ACC_W'(prod));
    end
    if (cmd.lclamp) begin
      acc_l <= ACC_W'(iq_clamped);
    end else if (cmd.lacc) begin
      acc_l <= acc_l + ACC_W'(prod);
    end
    if (cmd.rclamp) begin
      acc_r <= ACC_W'(iq_clamped);
    end else if (cmd.racc) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (cmd.out_load) begin
      left_drive  <= sat_drive(lsum);
      right_drive <= sat_drive(rsum);
    end
  end

endmodule

// ----- sv/lfdd_ctrl.sv -----
`include "line_follow_differential_drive_pid_unit_assert.svh"

module lfdd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lfdd_pkg::dp_cmd_t  cmd,
  input  lfdd_pkg::dp_stat_t stat
);
  import lfdd_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_TC   = 15'b000000000000010,
    S_SKP  = 15'b000000000000100,
    S_SKI  = 15'b000000000001000,
    S_SKD  = 15'b000000000010000,
    S_SFIN = 15'b000000000100000,
    S_LKI  = 15'b000000001000000,
    S_RKI  = 15'b000000010000000,
    S_LKP  = 15'b000000100000000,
    S_RKP  = 15'b000001000000000,
    S_LKD  = 15'b000010000000000,
    S_RKD  = 15'b000100000000000,
    S_DIVS = 15'b001000000000000,
    S_DIVW = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_TS;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TC;
        end
      end
      S_TC: begin
        cmd.sint    = 1'b1;
        cmd.mul_sel = MUL_TS;
        state_next  = S_SKP;
      end
      S_SKP: begin
        cmd.tcnt    = 1'b1;
        cmd.mul_sel = MUL_SKP;
        state_next  = S_SKI;
      end
      S_SKI: begin
        cmd.sacc_clr = 1'b1;
        cmd.err      = 1'b1;
        cmd.mul_sel  = MUL_SKI;
        state_next   = S_SKD;
      end
      S_SKD: begin
        cmd.sacc_add = 1'b1;
        cmd.wint     = 1'b1;
        cmd.mul_sel  = MUL_SKD;
        state_next   = S_SFIN;
      end
      S_SFIN: begin
        cmd.sfin    = 1'b1;
        cmd.mul_sel = MUL_WKI_L;
        state_next  = S_LKI;
      end
      S_LKI: begin
        cmd.lclamp  = 1'b1;
        cmd.mul_sel = MUL_WKI_R;
        state_next  = S_RKI;
      end
      S_RKI: begin
        cmd.rclamp  = 1'b1;
        cmd.mul_sel = MUL_WKP_L;
        state_next  = S_LKP;
      end
      S_LKP: begin
        cmd.lacc    = 1'b1;
        cmd.mul_sel = MUL_WKP_R;
        state_next  = S_RKP;
      end
      S_RKP: begin
        cmd.racc    = 1'b1;
        cmd.mul_sel = MUL_WKD_L;
        state_next  = S_LKD;
      end
      S_LKD: begin
        cmd.lacc    = 1'b1;
        cmd.mul_sel = MUL_WKD_R;
        state_next  = S_RKD;
      end
      S_RKD: begin
        cmd.racc   = 1'b1;
        cmd.prev   = 1'b1;
        state_next = stat.clamp_any ? S_DIVS : S_OUT;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.setback = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LFDD_ASSERT_NOW(a_out_load_free, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `LFDD_ASSERT_NOW(a_div_needs_clamp, cmd.div_start, stat.clamp_any, "divide without clamp")
  `LFDD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_TC, "accept did not start")
  `LFDD_ASSERT_NEXT(a_out_drop, out_valid && out_ready && !cmd.out_load, !out_valid, "beat repeated")

endmodule

// ----- sv/line_follow_differential_drive_pid_unit.sv -----
// Line-following differential-drive PID: one input beat per control tick gives one
// pair of saturated wheel drives. A tick is accepted, then one shared 24x33 multiplier
// works through the ten products in sequence; the next beat is taken only once the
// result is in the output register and the controller is idle again. When either
// wheel's integral term exceeds integral_limit, a bit-serial divider computes the integral
// set-back value in S_DIVS and S_DIVW, which lengthens that tick. A finished
// result waits in the output register while the next tick is accepted.
module line_follow_differential_drive_pid_unit #(
  parameter int GAIN_FRACTION_BITS = 8,
  parameter int DRIVE_WIDTH        = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  lfdd_in_if.sink                    tick,
  lfdd_out_if.source                 motor,
  input  logic                       wr_en,
  input  logic [lfdd_pkg::IDX_W-1:0] wr_index,
  input  logic [lfdd_pkg::CFG_W-1:0] wr_data
);
  import lfdd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lfdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (motor.valid),
    .out_ready (motor.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lfdd_datapath #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .DRIVE_WIDTH        (DRIVE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .trace_deviation (tick.trace_deviation),
    .left_count      (tick.left_count),
    .right_count     (tick.right_count),
    .target_speed    (tick.target_speed),
    .cmd             (cmd),
    .stat            (stat),
    .left_drive      (motor.left_drive),
    .right_drive     (motor.right_drive)
  );

endmodule

// ----- tb/sv/tb_line_follow_differential_drive_pid_unit.sv -----
`timescale 1ns / 100ps

module tb_line_follow_differential_drive_pid_unit;
  import lfdd_pkg::*;

  localparam int GAIN_FRAC = 8;
  localparam int DRIVE_W = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_TICKS = 75;
  localparam int RANDOM_PHASES = 12;
  localparam int unsigned GAIN_MAX = (1 << GAIN_W) - 1;
  localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int unsigned SCALE_MAX = (1 << SCALE_W) - 1;
  localparam longint GAIN_ONE = longint'(1) <<< GAIN_FRAC;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  typedef struct {
    logic signed [DEV_W-1:0] dev;
    logic signed [CNT_W-1:0] lc;
    logic signed [CNT_W-1:0] rc;
    logic signed [TS_W-1:0]  ts;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
  } drive_pair_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  lfdd_in_if tick_if ();
  lfdd_out_if #(.DRIVE_WIDTH(DRIVE_W)) motor_if ();

  line_follow_differential_drive_pid_unit #(
    .GAIN_FRACTION_BITS(GAIN_FRAC),
    .DRIVE_WIDTH(DRIVE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_if),
    .motor(motor_if),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // controller model: registers and loop state
  logic [CFG_W-1:0] ctl_reg [0:7];
  longint steer_sum, steer_last;
  longint left_sum, left_last;
  longint right_sum, right_last;

  drive_pair_t drives_due [$];
  int unsigned mismatches;
  int unsigned beat_no;

  // sender idling
  int unsigned burst_left;
  int unsigned burst_max;
  int unsigned gap_max;

  // receiver stall controls
  logic [15:0] stall_mask;
  int unsigned hold_len;
  int unsigned hold_seq;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic longint clamp_i32(longint v);
    return (v > I32_MAX) ? I32_MAX : ((v < I32_MIN) ? I32_MIN : v);
  endfunction

  function automatic logic signed [DRIVE_W-1:0] sat_drive(longint v);
    longint c;
    c = (v > DRIVE_MAX) ? DRIVE_MAX : ((v < DRIVE_MIN) ? DRIVE_MIN : v);
    return c[DRIVE_W-1:0];
  endfunction

  function automatic void reset_model();
    foreach (ctl_reg[i]) ctl_reg[i] = '0;
    ctl_reg[CFG_STEER_KP] = STEER_KP_RESET;
    ctl_reg[CFG_LIMIT] = LIMIT_RESET;
    ctl_reg[CFG_SCALE] = SCALE_RESET;
    steer_sum = 0;
    steer_last = 0;
    left_sum = 0;
    left_last = 0;
    right_sum = 0;
    right_last = 0;
  endfunction

  // one wheel's speed loop; integral term clamped, stored sum set back on clamp
  function automatic longint wheel_drive_term(input longint err, inout longint sum,
                                              inout longint last);
    longint lim, ki, iq;
    lim = longint'(ctl_reg[CFG_LIMIT]) <<< GAIN_FRAC;
    ki = longint'(ctl_reg[CFG_WHEEL_KI]);
    sum = clamp_i32(sum + err);
    iq = ki * sum;
    if (iq > lim) begin
      iq = lim;
      sum = lim / ki;
    end else if (iq < -lim) begin
      iq = -lim;
      sum = -(lim / ki);
    end
    iq += longint'(ctl_reg[CFG_WHEEL_KP]) * err
        + longint'(ctl_reg[CFG_WHEEL_KD]) * (err - last);
    last = err;
    return iq / GAIN_ONE;
  endfunction

  function automatic drive_pair_t predict_drives(tick_t t);
    drive_pair_t d;
    longint dev, steer, counts, lt, rt;
    dev = longint'(t.dev);
    steer_sum = clamp_i32(steer_sum + dev);
    steer = longint'(ctl_reg[CFG_STEER_KP]) * dev
          + longint'(ctl_reg[CFG_STEER_KI]) * steer_sum
          + longint'(ctl_reg[CFG_STEER_KD]) * (dev - steer_last);
    steer = steer / GAIN_ONE;
    steer_last = dev;
    counts = (longint'(t.ts) * longint'(ctl_reg[CFG_SCALE])) / (longint'(1) <<< SCALE_FRAC);
    lt = wheel_drive_term(counts - longint'(t.lc), left_sum, left_last);
    rt = wheel_drive_term(counts - longint'(t.rc), right_sum, right_last);
    d.left = sat_drive(lt - steer);
    d.right = sat_drive(steer + rt);
    return d;
  endfunction

  function automatic tick_t make_tick(int dev, int lc, int rc, int ts);
    tick_t t;
    t.dev = dev[DEV_W-1:0];
    t.lc = lc[CNT_W-1:0];
    t.rc = rc[CNT_W-1:0];
    t.ts = ts[TS_W-1:0];
    return t;
  endfunction

  // mostly counts near the commanded speed so the integrals wind up and clamp
  function automatic tick_t random_tick();
    int ts, tc, dev, lc, rc;
    ts = rand_between(-2000, 2000);
    tc = int'((longint'(ts) * longint'(ctl_reg[CFG_SCALE])) / (longint'(1) <<< SCALE_FRAC));
    dev = ($urandom_range(0, 3) == 0) ? rand_between(-1024, 1023) : rand_between(-48, 47);
    if ($urandom_range(0, 4) == 0) begin
      lc = rand_between(-32768, 32767);
      rc = rand_between(-32768, 32767);
    end else begin
      lc = tc + rand_between(-40, 40);
      rc = tc + rand_between(-40, 40);
    end
    return make_tick(dev, lc, rc, ts);
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  task automatic check_drive_beat();
    drive_pair_t want;
    beat_no++;
    if (drives_due.size() == 0) begin
      log_mismatch($sformatf("beat %0d: drive pair with none pending", beat_no));
      return;
    end
    want = drives_due.pop_front();
    if (motor_if.left_drive !== want.left)
      log_mismatch($sformatf("beat %0d: left_drive %0d, predicted %0d",
                             beat_no, motor_if.left_drive, want.left));
    if (motor_if.right_drive !== want.right)
      log_mismatch($sformatf("beat %0d: right_drive %0d, predicted %0d",
                             beat_no, motor_if.right_drive, want.right));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_LIMIT: ctl_reg[idx] = CFG_W'(value & LIMIT_MAX);
      CFG_SCALE: ctl_reg[idx] = CFG_W'(value & SCALE_MAX);
      default:   ctl_reg[idx] = CFG_W'(value & GAIN_MAX);
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_if.valid <= 1'b1;
    tick_if.trace_deviation <= t.dev;
    tick_if.left_count <= t.lc;
    tick_if.right_count <= t.rc;
    tick_if.target_speed <= t.ts;
    do @(posedge clk); while (tick_if.ready !== 1'b1);
    drives_due.push_back(predict_drives(t));
  endtask

  // sender pauses until every pending drive pair has come back
  task automatic drain_drives();
    tick_if.valid <= 1'b0;
    burst_left = 0;
    while (drives_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned gaps, input int unsigned bursts,
                            input logic [15:0] mask);
    gap_max = gaps;
    burst_max = bursts;
    burst_left = 0;
    stall_mask <= mask;
  endtask

  function automatic int unsigned rand_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return GAIN_MAX;
      2, 3, 4: return $urandom_range(0, 768);
      5: return $urandom_range(0, 8192);
      6: return $urandom_range(0, 131071);
      default: return $urandom_range(0, GAIN_MAX);
    endcase
  endfunction

  function automatic int unsigned rand_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return LIMIT_MAX;
      2, 3: return $urandom_range(0, 200);
      default: return $urandom_range(0, LIMIT_MAX);
    endcase
  endfunction

  function automatic int unsigned rand_scale();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return SCALE_MAX;
      default: return $urandom_range(0, SCALE_MAX);
    endcase
  endfunction

  // style 0: all zero, style 1: all at maximum, otherwise random
  task automatic load_config(input int unsigned style);
    int unsigned v;
    for (int i = 0; i < 8; i++) begin
      if (style == 0) v = 0;
      else if (style == 1) begin
        v = (cfg_idx_t'(i) == CFG_LIMIT) ? LIMIT_MAX :
            (cfg_idx_t'(i) == CFG_SCALE) ? SCALE_MAX : GAIN_MAX;
      end else begin
        v = (cfg_idx_t'(i) == CFG_LIMIT) ? rand_limit() :
            (cfg_idx_t'(i) == CFG_SCALE) ? rand_scale() : rand_gain();
      end
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  task automatic test_reset_config();
    set_idling(0, 1, 16'h0000);
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(1023, 32767, -32768, 2000));
    send_tick(make_tick(-1024, -32768, 32767, -2000));
    send_tick(make_tick(5, 0, 0, 0));
    drain_drives();
  endtask

  task automatic test_wheel_integral_clamp();
    set_idling(3, 4, 16'h0a0a);
    write_reg(CFG_STEER_KP, 256);
    write_reg(CFG_STEER_KI, 16);
    write_reg(CFG_STEER_KD, 512);
    write_reg(CFG_WHEEL_KP, 128);
    write_reg(CFG_WHEEL_KI, 256);
    write_reg(CFG_WHEEL_KD, 64);
    write_reg(CFG_LIMIT, 100);
    write_reg(CFG_SCALE, SCALE_MAX);
    repeat (3) send_tick(make_tick(10, 0, 0, 2000));
    send_tick(make_tick(-10, 0, 0, -2000));
    send_tick(make_tick(0, 32767, -32768, 0));
    send_tick(make_tick(0, -32768, 32767, 0));
    drain_drives();
    // zero integral gain: sums run free, no clamp even at a zero limit
    write_reg(CFG_WHEEL_KI, 0);
    write_reg(CFG_LIMIT, 0);
    repeat (3) send_tick(make_tick(100, -1000, 1000, 1500));
    drain_drives();
    // zero limit with nonzero gain clamps the sums to zero
    write_reg(CFG_WHEEL_KI, 3);
    send_tick(make_tick(-3, 500, -500, 0));
    send_tick(make_tick(3, -500, 500, 0));
    drain_drives();
  endtask

  task automatic test_gain_extremes();
    set_idling(2, 3, 16'h8001);
    load_config(1);
    send_tick(make_tick(1023, -32768, 32767, 2000));
    send_tick(make_tick(-1024, 32767, -32768, -2000));
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(1, 1, -1, 1));
    drain_drives();
  endtask

  // long receiver hold-off while the sender keeps offering: input must stall
  task automatic test_output_backpressure();
    load_config(2);
    set_idling(0, 1, 16'h0000);
    hold_len <= 400;
    hold_seq <= hold_seq + 1;
    repeat (12) send_tick(random_tick());
    drain_drives();
  endtask

  task automatic test_random_ticks();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_config((p < 2) ? p : 2);
      if (p % 3 == 0) set_idling(0, 1, 16'h0000);
      else set_idling($urandom_range(1, 8), $urandom_range(1, 16), 16'($urandom & $urandom));
      repeat (PHASE_TICKS) send_tick(random_tick());
      drain_drives();
    end
  endtask

  initial begin : motor_sink
    int unsigned hold_seen;
    int unsigned hold_cnt;
    logic [3:0] stall_pos;
    hold_seen = 0;
    hold_cnt = 0;
    stall_pos = '0;
    motor_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (motor_if.valid === 1'b1 && motor_if.ready === 1'b1) check_drive_beat();
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_cnt = hold_len;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        motor_if.ready <= 1'b0;
      end else begin
        motor_if.ready <= !stall_mask[stall_pos];
      end
      stall_pos++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((tick_if.valid === 1'b1 && tick_if.ready === 1'b1) ||
          (motor_if.valid === 1'b1 && motor_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", quiet);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    mismatches = 0;
    beat_no = 0;
    burst_left = 0;
    burst_max = 1;
    gap_max = 0;
    hold_len = 0;
    hold_seq = 0;
    stall_mask = '0;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    tick_if.valid <= 1'b0;
    tick_if.trace_deviation <= '0;
    tick_if.left_count <= '0;
    tick_if.right_count <= '0;
    tick_if.target_speed <= '0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_wheel_integral_clamp();
    test_gain_extremes();
    test_output_backpressure();
    test_random_ticks();
    drain_drives();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- line_follow_differential_drive_pid_unit.f -----
+incdir+sv
sv/lfdd_pkg.sv
sv/lfdd_if.sv
sv/lfdd_div.sv
sv/lfdd_datapath.sv
sv/lfdd_ctrl.sv
sv/line_follow_differential_drive_pid_unit.sv
tb/sv/tb_line_follow_differential_drive_pid_unit.sv
